@@ design/sppd_pkg.sv @@
// Shared types and constants of the stereo ping-pong delay unit.
`timescale 1ns / 1ps

package sppd_pkg;

    typedef logic signed [15:0] t_sample;

    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] UNITY      = 16'd32768;
    localparam logic [15:0] DELAY_RST  = 16'd1;
    localparam logic [15:0] FB_RST     = 16'd16384;
    localparam logic [15:0] WET_RST    = 16'd4915;

    typedef enum logic [1:0] {
        CFG_DELAY,
        CFG_FEEDBACK,
        CFG_WET,
        CFG_PAN
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PAN_CENTER,
        PAN_LEFT,
        PAN_RIGHT
    } t_pan;

endpackage

@@ design/sppd_in_if.sv @@
// Input channel interface carrying one stereo sample pair per transfer.
`timescale 1ns / 1ps

interface sppd_in_if;
    import sppd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample left_in;
    t_sample right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

@@ design/sppd_out_if.sv @@
// Output channel interface carrying one mixed stereo sample pair per transfer.
`timescale 1ns / 1ps

interface sppd_out_if;
    import sppd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample left_out;
    t_sample right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ design/stereo_ping_pong_delay_unit.sv @@
// Stereo ping-pong delay with two-bank delay store, single-pass mix and output register.
`timescale 1ns / 1ps

// Usage:
// Stereo pairs arrive on i_in and mixed pairs leave on o_out, one result per
// input transfer, in order. Both channels use a valid/ready handshake.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_data; keeping
// those writes to when the unit is idle is up to the user, as the unit has no guard for it.
// The delay store is read at the input transfer; the mix and feedback sums are
// then computed from the read data and loaded into the output register.
// Throughput is one pair per cycle while o_out.ready is high. Each pair needs
// one read and two writes of the store, so the store is split into even and
// odd banks with one write port each; a clear of the read slot that collides
// with the feedback write is held pending and done when that bank's write
// port is next free. After reset the unit sweeps both banks to zero, one row
// per cycle, over DEPTH/2 rows (32768 by default); i_in.ready stays low meanwhile.
// When the receiver stalls, the output register holds its result and one
// more pair may enter and wait in the compute stage; then i_in.ready drops.
module stereo_ping_pong_delay_unit #(
    parameter int ADDR_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sppd_in_if.sink            i_in,
    sppd_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  sppd_pkg::t_cfg_idx i_cfg_idx,
    input  logic [sppd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sppd_pkg::*;

    localparam int DEPTH      = 1 << ADDR_W;
    localparam int BANK_AW    = (ADDR_W > 1) ? ADDR_W - 1 : 1;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int CMP_W      = ((ADDR_W > 16) ? ADDR_W : 16) + 1;

    function automatic t_sample sat16(input logic signed [18:0] x);
        if (x > 19'sd32767) begin
            return 16'sh7fff;
        end
        if (x < -19'sd32768) begin
            return -16'sh8000;
        end
        return x[15:0];
    endfunction

    function automatic logic [BANK_AW-1:0] bank_row(input logic [ADDR_W-1:0] a);
        return BANK_AW'(a >> 1);
    endfunction

    // Configuration registers.
    logic [15:0] r_delay;
    logic [15:0] r_fb;
    logic [15:0] r_wet;
    logic [1:0]  r_pan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RST;
            r_fb    <= FB_RST;
            r_wet   <= WET_RST;
            r_pan   <= PAN_CENTER;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY:    r_delay <= i_cfg_data;
                CFG_FEEDBACK: r_fb    <= i_cfg_data;
                CFG_WET:      r_wet   <= i_cfg_data;
                CFG_PAN:      r_pan   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Control and pipeline registers.
    logic                r_clearing;
    logic [BANK_AW-1:0]  r_clr_idx;
    logic [ADDR_W-1:0]   r_rp;
    logic                r_s1_v;
    t_sample             r_s1_lin;
    t_sample             r_s1_rin;
    logic [ADDR_W-1:0]   r_s1_rp;
    logic                r_s1_fwd;
    logic [31:0]         r_s1_fwd_data;
    logic [31:0]         r_q0;
    logic [31:0]         r_q1;
    logic                r_pend_v;
    logic [ADDR_W-1:0]   r_pend_addr;
    logic                r_ov;
    t_sample             r_lout;
    t_sample             r_rout;
    logic [31:0]         r_mem0 [BANK_DEPTH];
    logic [31:0]         r_mem1 [BANK_DEPTH];

    logic in_acc;
    logic s1_adv;

    assign s1_adv     = r_s1_v && (!r_ov || o_out.ready);
    assign i_in.ready = !r_clearing && (!r_s1_v || s1_adv);
    assign in_acc     = i_in.valid && i_in.ready;

    // Effective delay and write address.
    logic [CMP_W-1:0]  d_wide;
    logic [CMP_W-1:0]  d_clamped;
    logic [ADDR_W-1:0] wp;

    always_comb begin
        d_wide = CMP_W'(r_delay);
        if (d_wide == '0) begin
            d_clamped = CMP_W'(1);
        end else if (d_wide > CMP_W'(DEPTH - 1)) begin
            d_clamped = CMP_W'(DEPTH - 1);
        end else begin
            d_clamped = d_wide;
        end
    end

    assign wp = r_s1_rp + ADDR_W'(d_clamped);

    // Mix and feedback arithmetic.
    logic [31:0]         s1_word;
    t_sample             l_del;
    t_sample             r_del;
    logic [15:0]         wet_c;
    logic [15:0]         dry;
    logic [15:0]         fb_c;
    logic signed [33:0]  mix_l;
    logic signed [33:0]  mix_r;
    logic signed [32:0]  fbp_r;
    logic signed [32:0]  fbp_l;
    logic signed [17:0]  fb_from_r;
    logic signed [17:0]  fb_from_l;
    logic signed [16:0]  pair_sum;
    t_sample             avg;
    logic signed [18:0]  new_l;
    logic signed [18:0]  new_r;
    t_sample             lout_sat;
    t_sample             rout_sat;
    t_sample             store_l;
    t_sample             store_r;

    always_comb begin
        s1_word = r_s1_fwd ? r_s1_fwd_data : (r_s1_rp[0] ? r_q1 : r_q0);
        l_del   = s1_word[31:16];
        r_del   = s1_word[15:0];
        wet_c   = (r_wet > UNITY) ? UNITY : r_wet;
        dry     = UNITY - wet_c;
        fb_c    = (r_fb > UNITY) ? UNITY : r_fb;

        mix_l = 34'(33'(r_s1_lin) * 33'($signed({1'b0, dry})))
              + 34'(33'(l_del) * 33'($signed({1'b0, wet_c})))
              + 34'sd16384;
        mix_r = 34'(33'(r_s1_rin) * 33'($signed({1'b0, dry})))
              + 34'(33'(r_del) * 33'($signed({1'b0, wet_c})))
              + 34'sd16384;
        lout_sat = sat16(mix_l[33:15]);
        rout_sat = sat16(mix_r[33:15]);

        fbp_r     = 33'(r_del) * 33'($signed({1'b0, fb_c})) + 33'sd16384;
        fbp_l     = 33'(l_del) * 33'($signed({1'b0, fb_c})) + 33'sd16384;
        fb_from_r = fbp_r[32:15];
        fb_from_l = fbp_l[32:15];

        pair_sum = 17'(r_s1_lin) + 17'(r_s1_rin);
        avg      = pair_sum[16:1];

        case (r_pan)
            PAN_CENTER: begin
                new_l = 19'(r_s1_lin) + 19'(fb_from_r);
                new_r = 19'(r_s1_rin) + 19'(fb_from_l);
            end
            PAN_LEFT: begin
                new_l = 19'(avg) + 19'(fb_from_r);
                new_r = 19'(fb_from_l);
            end
            default: begin
                new_l = 19'(fb_from_r);
                new_r = 19'(avg) + 19'(fb_from_l);
            end
        endcase
        store_l = sat16(new_l);
        store_r = sat16(new_r);
    end

    // Write scheduling for the two banks.
    logic               w_en   [2];
    logic [BANK_AW-1:0] w_row  [2];
    logic [31:0]        w_data [2];
    logic               conflict;
    logic               pend_fire;
    logic               n_pend_v;
    logic [ADDR_W-1:0]  n_pend_addr;

    assign conflict = s1_adv && (wp[0] == r_s1_rp[0]);

    always_comb begin
        pend_fire = 1'b0;
        for (int b = 0; b < 2; b++) begin
            w_en[b]   = 1'b0;
            w_row[b]  = r_clr_idx;
            w_data[b] = '0;
            if (r_clearing) begin
                w_en[b] = 1'b1;
            end else if (s1_adv && wp[0] == 1'(b)) begin
                w_en[b]   = 1'b1;
                w_row[b]  = bank_row(wp);
                w_data[b] = {store_l, store_r};
            end else if (s1_adv && r_s1_rp[0] == 1'(b)) begin
                w_en[b]  = 1'b1;
                w_row[b] = bank_row(r_s1_rp);
            end else if (r_pend_v && r_pend_addr[0] == 1'(b)) begin
                w_en[b]   = 1'b1;
                w_row[b]  = bank_row(r_pend_addr);
                pend_fire = 1'b1;
            end
        end
        n_pend_v    = conflict || (r_pend_v && !pend_fire);
        n_pend_addr = conflict ? r_s1_rp : r_pend_addr;
    end

    // Read of the store at the read pointer, with bypass of a same-edge write.
    logic [BANK_AW-1:0] rd_row;
    logic               rd_bank;

    assign rd_row  = bank_row(r_rp);
    assign rd_bank = r_rp[0];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_mem0[w_row[0]] <= w_data[0];
        end
        if (in_acc && !rd_bank) begin
            r_q0 <= r_mem0[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_mem1[w_row[1]] <= w_data[1];
        end
        if (in_acc && rd_bank) begin
            r_q1 <= r_mem1[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_rp       <= '0;
            r_s1_v     <= 1'b0;
            r_pend_v   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + BANK_AW'(1);
                if (r_clr_idx == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_acc) begin
                r_rp   <= r_rp + ADDR_W'(1);
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            r_pend_v <= n_pend_v;
            if (s1_adv) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        if (in_acc) begin
            r_s1_lin      <= i_in.left_in;
            r_s1_rin      <= i_in.right_in;
            r_s1_rp       <= r_rp;
            r_s1_fwd      <= w_en[rd_bank] && (w_row[rd_bank] == rd_row);
            r_s1_fwd_data <= w_data[rd_bank];
        end
        if (s1_adv) begin
            r_lout <= lout_sat;
            r_rout <= rout_sat;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.left_out  = r_lout;
    assign o_out.right_out = r_rout;

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_in.ready)
        else $error("Input transfer possible during the store clearing sweep.");

    a_rp_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_rp == $past(r_rp) + ADDR_W'(1)))
        else $error("Read pointer did not advance by one after an input transfer.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_ov)
        else $error("Output register not loaded after the compute stage advanced.");

    a_pending_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && !s1_adv) |=> !r_pend_v)
        else $error("Deferred slot clear was not written in an idle cycle.");
`endif

endmodule
